// ===== hdl/rstpp_pkg.sv =====
// shared types and constants of the rgb scale, threshold and page pack block
`default_nettype none
package rstpp_pkg;

  // pixel component and packed store word
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;

  // configuration register width and default image size
  localparam int DIM_W = 9;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = 9'd128;
  localparam logic [DIM_W-1:0] SRC_HEIGHT_RST = 9'd64;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_SRC_WIDTH  = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;

  // display frame geometry: 128 x 64, x and y bit counts
  localparam int FRAME_X_W = 7;
  localparam int FRAME_Y_W = 6;

  // chunk layout: 64 chunks of 16 bytes, 128 pixels each
  localparam int CHUNK_IDX_W = 6;
  localparam int CHUNK_PIX_W = 7;
  localparam int CHUNK_BITS  = 128;
  localparam int HALF_BITS   = 64;
  localparam logic [CHUNK_IDX_W-1:0] CHUNK_LAST = 6'd63;
  localparam logic [CHUNK_PIX_W-1:0] PIX_LAST   = 7'd127;

  // luma weights and threshold (luma at least 129)
  localparam int LUMA_W = 18;
  localparam logic [9:0] COEF_R = 10'd299;
  localparam logic [9:0] COEF_G = 10'd587;
  localparam logic [9:0] COEF_B = 10'd114;
  localparam logic [LUMA_W-1:0] LUMA_LIMIT = 18'd129000;

  // controller to datapath commands
  typedef struct packed {
    logic                 load;
    logic                 start;
    logic                 issue;
    logic [FRAME_X_W-1:0] x;
    logic [FRAME_Y_W-1:0] y;
  } rstpp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic busy;
  } rstpp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/rstpp_if.sv =====
// stream interfaces for source pixels and packed frame chunks
`default_nettype none
interface rstpp_pix_if import rstpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface rstpp_chunk_if import rstpp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CHUNK_IDX_W-1:0] chunk_index;
  logic [HALF_BITS-1:0]   bytes_low;
  logic [HALF_BITS-1:0]   bytes_high;
  logic                   last_chunk;

  modport source (output valid, chunk_index, bytes_low, bytes_high, last_chunk, input ready);
  modport sink   (input valid, chunk_index, bytes_low, bytes_high, last_chunk, output ready);
endinterface
`default_nettype wire

// ===== hdl/rgb_scale_threshold_page_pack.sv =====
// top level: rgb image to 128x64 one-bit page-packed frame converter
//
// Source pixels arrive on pix_i, one beat per pixel in raster order, at one
// beat per cycle; each is written to the internal pixel store up to its
// capacity. A beat with last_pixel set ends the image and starts the
// conversion; pix_i.ready stays low until the whole frame has left. The frame
// goes out on chunk_o as 64 beats of 16 bytes, chunk 0 first, last_chunk set
// on chunk 63. Each chunk is built by a scan of 128 store reads, one per cycle
// through the single read port, then a wait for the 4 stage read and
// threshold pipeline to empty before the chunk is offered. A stalled beat
// holds its payload and the conversion waits until it is taken.
// Image size comes from the src_width and src_height registers on the APB
// port (byte addresses 0 and 4), read when the last pixel arrives; write them
// only while the block is idle. Reset returns the sizes to 128 x 64 and the
// load position to zero; the store contents are not cleared.
`default_nettype none
module rgb_scale_threshold_page_pack import rstpp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready,
  rstpp_pix_if.sink              pix_i,
  rstpp_chunk_if.source          chunk_o
);

  logic [DIM_W-1:0]       width_q;
  logic [DIM_W-1:0]       height_q;
  logic                   reg_sel;
  rstpp_cmd_t             cmd;
  rstpp_sts_t             sts;
  logic [CHUNK_IDX_W-1:0] chunk_idx;
  logic                   chunk_last;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SRC_WIDTH_RST;
      height_q <= SRC_HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_SRC_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_SRC_WIDTH:  prdata = APB_DW'(width_q);
      REG_SRC_HEIGHT: prdata = APB_DW'(height_q);
      default:        prdata = '0;
    endcase
  end

  // sequencing
  rstpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_last_i   (pix_i.last_pixel),
    .in_ready_o  (pix_i.ready),
    .out_ready_i (chunk_o.ready),
    .out_valid_o (chunk_o.valid),
    .out_last_o  (chunk_last),
    .chunk_idx_o (chunk_idx),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // store and sample pipeline
  rstpp_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .red_i        (pix_i.red),
    .green_i      (pix_i.green),
    .blue_i       (pix_i.blue),
    .src_width_i  (width_q),
    .src_height_i (height_q),
    .bytes_low_o  (chunk_o.bytes_low),
    .bytes_high_o (chunk_o.bytes_high)
  );

  assign chunk_o.chunk_index = chunk_idx;
  assign chunk_o.last_chunk  = chunk_last;

endmodule
`default_nettype wire

// ===== hdl/rstpp_ctrl.sv =====
// controller: load, scan, drain and emit sequencing of the frame conversion
`default_nettype none
module rstpp_ctrl import rstpp_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_last_i,
  output logic                        in_ready_o,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic                        out_last_o,
  output logic [CHUNK_IDX_W-1:0]      chunk_idx_o,
  output rstpp_cmd_t                  cmd_o,
  input  wire rstpp_sts_t             sts_i
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [CHUNK_IDX_W-1:0] chunk_q, chunk_d;
  logic [CHUNK_PIX_W-1:0] pix_q, pix_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    chunk_d     = chunk_q;
    pix_d       = pix_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.x     = {chunk_q[2:0], pix_q[6:3]};
    cmd_o.y     = {chunk_q[5:3], pix_q[2:0]};
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && in_last_i) begin
          cmd_o.start = 1'b1;
          chunk_d     = '0;
          pix_d       = '0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        pix_d       = pix_q + 1'b1;
        if (pix_q == PIX_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (chunk_q == CHUNK_LAST) begin
            state_d = ST_LOAD;
          end else begin
            chunk_d = chunk_q + 1'b1;
            pix_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign chunk_idx_o = chunk_q;
  assign out_last_o  = (chunk_q == CHUNK_LAST);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      chunk_q <= '0;
      pix_q   <= '0;
    end else begin
      state_q <= state_d;
      chunk_q <= chunk_d;
      pix_q   <= pix_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rstpp_dpath.sv =====
// datapath: pixel store, sample address pipeline, luma threshold, chunk shifter
`default_nettype none
module rstpp_dpath import rstpp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rstpp_cmd_t        cmd_i,
  output rstpp_sts_t             sts_o,
  input  wire logic [CHAN_W-1:0] red_i,
  input  wire logic [CHAN_W-1:0] green_i,
  input  wire logic [CHAN_W-1:0] blue_i,
  input  wire logic [DIM_W-1:0]  src_width_i,
  input  wire logic [DIM_W-1:0]  src_height_i,
  output logic [HALF_BITS-1:0]   bytes_low_o,
  output logic [HALF_BITS-1:0]   bytes_high_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);

  logic [PIX_W-1:0]      mem_q [DEPTH];
  logic [LW-1:0]         load_q;
  logic                  wr_en;
  logic [WW-1:0]         w_q, w_d;
  logic [HW-1:0]         h_q, h_d;
  logic [FRAME_X_W+WW-1:0] xprod;
  logic [FRAME_Y_W+HW-1:0] yprod;
  logic [WW-1:0]         sx_q;
  logic [HW-1:0]         sy_q;
  logic [WW+HW-1:0]      aprod;
  logic [AW-1:0]         addr_q;
  logic [PIX_W-1:0]      rdata_q;
  logic [LUMA_W-1:0]     luma;
  logic                  on_q;
  logic                  v1_q, v2_q, v3_q, v4_q;
  logic [CHUNK_BITS-1:0] vec_q;

  // clamp the image size to one pixel and to the store bounds
  always_comb begin
    if (src_width_i == '0) begin
      w_d = WW'(1);
    end else if (32'(src_width_i) > 32'(MAX_WIDTH)) begin
      w_d = WW'(MAX_WIDTH);
    end else begin
      w_d = WW'(src_width_i);
    end
    if (src_height_i == '0) begin
      h_d = HW'(1);
    end else if (32'(src_height_i) > 32'(MAX_HEIGHT)) begin
      h_d = HW'(MAX_HEIGHT);
    end else begin
      h_d = HW'(src_height_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      w_q <= w_d;
      h_q <= h_d;
    end
  end

  // load address, saturating at store capacity, cleared after the last pixel
  assign wr_en = cmd_i.load && (load_q < LW'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
    end else if (cmd_i.start) begin
      load_q <= '0;
    end else if (wr_en) begin
      load_q <= load_q + 1'b1;
    end
  end

  // nearest source column and row
  assign xprod = cmd_i.x * w_q;
  assign yprod = cmd_i.y * h_q;

  always_ff @(posedge clk_i) begin
    sx_q <= xprod[FRAME_X_W +: WW];
    sy_q <= yprod[FRAME_Y_W +: HW];
  end

  // store address of the sample
  assign aprod = sy_q * w_q;

  always_ff @(posedge clk_i) begin
    addr_q <= AW'(aprod + (WW + HW)'(sx_q));
  end

  // pixel store: write while loading, registered read while scanning
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[load_q[AW-1:0]] <= {red_i, green_i, blue_i};
    end
    rdata_q <= mem_q[addr_q];
  end

  // luma threshold
  assign luma = COEF_R * rdata_q[2*CHAN_W +: CHAN_W]
              + COEF_G * rdata_q[CHAN_W +: CHAN_W]
              + COEF_B * rdata_q[0 +: CHAN_W];

  always_ff @(posedge clk_i) begin
    on_q <= (luma >= LUMA_LIMIT);
  end

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // chunk shifter: pixel n of the chunk lands at bit n
  always_ff @(posedge clk_i) begin
    if (v4_q) begin
      vec_q <= {on_q, vec_q[CHUNK_BITS-1:1]};
    end
  end

  assign sts_o.busy   = v1_q | v2_q | v3_q | v4_q;
  assign bytes_low_o  = vec_q[HALF_BITS-1:0];
  assign bytes_high_o = vec_q[CHUNK_BITS-1:HALF_BITS];

endmodule
`default_nettype wire
